// ----- sv/dpq_pkg.sv -----
// Package: shared constants, register indexes, status codes and types for the pump qualifier.
package dpq_pkg;

   localparam int unsigned RUN_W   = 8;
   localparam int unsigned TIME_W  = 32;
   localparam int unsigned CSR_W   = 32;
   localparam int unsigned IDX_W   = 3;
   localparam int unsigned STAT_W  = 3;

   localparam logic [RUN_W-1:0] RUN_MAX = '1;

   // register indexes
   localparam logic [IDX_W-1:0] REG_ON_THRESHOLD     = 3'd0;
   localparam logic [IDX_W-1:0] REG_OFF_THRESHOLD    = 3'd1;
   localparam logic [IDX_W-1:0] REG_DROP_THRESHOLD   = 3'd2;
   localparam logic [IDX_W-1:0] REG_DROP_COOLDOWN_MS = 3'd3;
   localparam logic [IDX_W-1:0] REG_MAX_PUMP_MS      = 3'd4;

   // register reset values
   localparam logic [RUN_W-1:0]  ON_THRESHOLD_RST     = 8'd3;
   localparam logic [RUN_W-1:0]  OFF_THRESHOLD_RST    = 8'd15;
   localparam logic [RUN_W-1:0]  DROP_THRESHOLD_RST   = 8'd240;
   localparam logic [TIME_W-1:0] DROP_COOLDOWN_MS_RST = 32'd15000;
   localparam logic [TIME_W-1:0] MAX_PUMP_MS_RST      = 32'd20000;

   // status codes
   localparam logic [STAT_W-1:0] STATUS_READY    = 3'd0;
   localparam logic [STAT_W-1:0] STATUS_RELEASED = 3'd1;
   localparam logic [STAT_W-1:0] STATUS_PUMP_A   = 3'd2;
   localparam logic [STAT_W-1:0] STATUS_PUMP_B   = 3'd3;
   localparam logic [STAT_W-1:0] STATUS_FAULT    = 3'd4;

   // per-line control from the top level to a line qualifier
   typedef struct packed {
      logic step;      // process one sample this cycle
      logic line_low;  // sampled line level, 1 = low
      logic wd_clear;  // watchdog drops the active flag
   } qual_ctrl_type;

   function automatic logic [RUN_W-1:0] sat_inc(input logic [RUN_W-1:0] v);
      sat_inc = (v == RUN_MAX) ? RUN_MAX : v + RUN_W'(1);
   endfunction

endpackage

// ----- sv/dpq_ifs.sv -----
// Interfaces: sample channel and result channel with valid/ready handshake.
interface dpq_req_if;
   logic                         valid;
   logic                         ready;
   logic                         line_a_low;
   logic                         line_b_low;
   logic [dpq_pkg::TIME_W-1:0]   now_ms;

   modport source (output valid, output line_a_low, output line_b_low, output now_ms,
                   input ready);
   modport sink   (input valid, input line_a_low, input line_b_low, input now_ms,
                   output ready);
endinterface

interface dpq_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         pump_a_on;
   logic                         pump_b_on;
   logic                         cup_release;
   logic                         release_blocked;
   logic                         watchdog_trip;
   logic [dpq_pkg::STAT_W-1:0]   status_code;

   modport source (output valid, output pump_a_on, output pump_b_on, output cup_release,
                   output release_blocked, output watchdog_trip, output status_code,
                   input ready);
   modport sink   (input valid, input pump_a_on, input pump_b_on, input cup_release,
                   input release_blocked, input watchdog_trip, input status_code,
                   output ready);
endinterface

// ----- sv/dpq_line_qual.sv -----
// Line qualifier: asymmetric low/high run counters and the active flag of one command line.
module dpq_line_qual (
   input  logic                        clock,
   input  logic                        reset,
   input  dpq_pkg::qual_ctrl_type      ctrl,
   input  logic [dpq_pkg::RUN_W-1:0]   on_threshold,
   input  logic [dpq_pkg::RUN_W-1:0]   off_threshold,
   output logic                        active_q      // qualified flag for this sample
);

   logic [dpq_pkg::RUN_W-1:0] low_run_ff, low_run_in;
   logic [dpq_pkg::RUN_W-1:0] high_run_ff, high_run_in;
   logic                      active_ff, active_in;
   logic [dpq_pkg::RUN_W-1:0] low_inc, high_inc;

   assign low_inc  = dpq_pkg::sat_inc(low_run_ff);
   assign high_inc = dpq_pkg::sat_inc(high_run_ff);

   always_comb begin
      if (ctrl.line_low) begin
         low_run_in  = low_inc;
         high_run_in = '0;
         active_q    = active_ff | (low_inc >= on_threshold);
      end else begin
         low_run_in  = '0;
         high_run_in = high_inc;
         active_q    = active_ff & ~(high_inc >= off_threshold);
      end
      active_in = active_q & ~ctrl.wd_clear;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         low_run_ff  <= '0;
         high_run_ff <= '0;
         active_ff   <= 1'b0;
      end else if (ctrl.step) begin
         low_run_ff  <= low_run_in;
         high_run_ff <= high_run_in;
         active_ff   <= active_in;
      end
   end

endmodule

// ----- sv/dual_pump_qualifier_with_watchdog_top.sv -----
// Top level: dual pump command qualifier with cup release cooldown and pump watchdog.
//
//   channel | ports        | direction | carries
//   --------+--------------+-----------+------------------------------------------------
//   sample  | req_ch       | in        | line_a_low, line_b_low, now_ms
//   result  | rsp_ch       | out       | pump_a_on, pump_b_on, cup_release,
//           |              |           | release_blocked, watchdog_trip, status_code
//   csr     | csr_we/index | in        | write-only registers, index 0..4, 32-bit data
//
// One sample per cycle sustained while rsp_ch.ready stays high. An accepted sample enters
// the input register and moves into the result register when that is empty or taken;
// its result is taken from there. All state updates in the cycle a sample moves from the
// input register into the result register.
// Synchronous active-high reset restores the register defaults, clears all counters
// and shows status fault. A stalled result holds the input register; a new sample is
// still taken while the result register is full as long as the input register drains.
module dual_pump_qualifier_with_watchdog_top (
   input  logic                          clock,
   input  logic                          reset,
   dpq_req_if.sink                       req_ch,
   dpq_rsp_if.source                     rsp_ch,
   input  logic                          csr_we,
   input  logic [dpq_pkg::IDX_W-1:0]     csr_index,
   input  logic [dpq_pkg::CSR_W-1:0]     csr_wdata
);

   // configuration registers
   logic [dpq_pkg::RUN_W-1:0]  on_th_ff, off_th_ff, drop_th_ff;
   logic [dpq_pkg::TIME_W-1:0] cooldown_ff, max_pump_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         on_th_ff    <= dpq_pkg::ON_THRESHOLD_RST;
         off_th_ff   <= dpq_pkg::OFF_THRESHOLD_RST;
         drop_th_ff  <= dpq_pkg::DROP_THRESHOLD_RST;
         cooldown_ff <= dpq_pkg::DROP_COOLDOWN_MS_RST;
         max_pump_ff <= dpq_pkg::MAX_PUMP_MS_RST;
      end else if (csr_we) begin
         case (csr_index)
            dpq_pkg::REG_ON_THRESHOLD:     on_th_ff    <= csr_wdata[dpq_pkg::RUN_W-1:0];
            dpq_pkg::REG_OFF_THRESHOLD:    off_th_ff   <= csr_wdata[dpq_pkg::RUN_W-1:0];
            dpq_pkg::REG_DROP_THRESHOLD:   drop_th_ff  <= csr_wdata[dpq_pkg::RUN_W-1:0];
            dpq_pkg::REG_DROP_COOLDOWN_MS: cooldown_ff <= csr_wdata[dpq_pkg::TIME_W-1:0];
            dpq_pkg::REG_MAX_PUMP_MS:      max_pump_ff <= csr_wdata[dpq_pkg::TIME_W-1:0];
            default: ;
         endcase
      end
   end

   // handshake and input register
   logic                       s1_valid_ff, s1_valid_in;
   logic                       s1_a_low_ff, s1_b_low_ff;
   logic [dpq_pkg::TIME_W-1:0] s1_now_ff;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       advance, req_take;

   assign advance      = s1_valid_ff & (~rsp_valid_ff | rsp_ch.ready);
   assign req_ch.ready = ~s1_valid_ff | advance;
   assign req_take     = req_ch.valid & req_ch.ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_take)
         s1_valid_in = 1'b1;
      else if (advance)
         s1_valid_in = 1'b0;
      rsp_valid_in = rsp_valid_ff;
      if (advance)
         rsp_valid_in = 1'b1;
      else if (rsp_ch.ready)
         rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_a_low_ff <= req_ch.line_a_low;
         s1_b_low_ff <= req_ch.line_b_low;
         s1_now_ff   <= req_ch.now_ms;
      end
   end

   // line qualifiers
   dpq_pkg::qual_ctrl_type qa_ctrl, qb_ctrl;
   logic                   act_a, act_b;
   logic                   trip;

   assign qa_ctrl = '{step: advance, line_low: s1_a_low_ff, wd_clear: trip};
   assign qb_ctrl = '{step: advance, line_low: s1_b_low_ff, wd_clear: trip};

   dpq_line_qual u_qual_a (
      .clock         (clock),
      .reset         (reset),
      .ctrl          (qa_ctrl),
      .on_threshold  (on_th_ff),
      .off_threshold (off_th_ff),
      .active_q      (act_a)
   );

   dpq_line_qual u_qual_b (
      .clock         (clock),
      .reset         (reset),
      .ctrl          (qb_ctrl),
      .on_threshold  (on_th_ff),
      .off_threshold (off_th_ff),
      .active_q      (act_b)
   );

   // shared state
   logic [dpq_pkg::RUN_W-1:0]  both_run_ff, both_run_in;
   logic                       release_done_ff, release_done_in;
   logic [dpq_pkg::TIME_W-1:0] last_rel_ff, last_rel_in;
   logic [dpq_pkg::TIME_W-1:0] start_ff, start_in;
   logic                       timing_ff, timing_in;
   logic                       relay_a_ff, relay_a_in;
   logic                       relay_b_ff, relay_b_in;
   logic [dpq_pkg::STAT_W-1:0] status_ff, status_in;
   logic                       pulse, blocked;
   logic [dpq_pkg::TIME_W-1:0] since_rel, since_start;
   logic                       timing_br;

   assign since_rel = s1_now_ff - last_rel_ff;

   always_comb begin
      both_run_in     = (s1_a_low_ff & s1_b_low_ff) ? dpq_pkg::sat_inc(both_run_ff) : '0;
      release_done_in = release_done_ff;
      last_rel_in     = last_rel_ff;
      start_in        = start_ff;
      timing_br       = timing_ff;
      relay_a_in      = relay_a_ff;
      relay_b_in      = relay_b_ff;
      status_in       = status_ff;
      pulse           = 1'b0;
      blocked         = 1'b0;

      if ((both_run_in >= drop_th_ff) && act_a && act_b) begin
         if (!release_done_ff) begin
            if (since_rel >= cooldown_ff) begin
               last_rel_in = s1_now_ff;
               relay_a_in  = 1'b0;
               relay_b_in  = 1'b0;
               pulse       = 1'b1;
               status_in   = dpq_pkg::STATUS_RELEASED;
            end else begin
               blocked = 1'b1;
            end
            release_done_in = 1'b1;
         end
      end else if (act_a && !act_b) begin
         release_done_in = 1'b0;
         relay_a_in      = 1'b1;
         relay_b_in      = 1'b0;
         status_in       = dpq_pkg::STATUS_PUMP_A;
         if (!timing_ff) begin
            timing_br = 1'b1;
            start_in  = s1_now_ff;
         end
      end else if (!act_a && act_b) begin
         release_done_in = 1'b0;
         relay_a_in      = 1'b0;
         relay_b_in      = 1'b1;
         status_in       = dpq_pkg::STATUS_PUMP_B;
         if (!timing_ff) begin
            timing_br = 1'b1;
            start_in  = s1_now_ff;
         end
      end else if (!act_a && !act_b) begin
         release_done_in = 1'b0;
         relay_a_in      = 1'b0;
         relay_b_in      = 1'b0;
         timing_br       = 1'b0;
         status_in       = dpq_pkg::STATUS_READY;
      end

      // watchdog sees the pump timer as left by the branch above
      since_start = s1_now_ff - start_in;
      trip        = timing_br & (since_start > max_pump_ff);
      timing_in   = timing_br;
      if (trip) begin
         relay_a_in = 1'b0;
         relay_b_in = 1'b0;
         timing_in  = 1'b0;
         status_in  = dpq_pkg::STATUS_FAULT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         both_run_ff     <= '0;
         release_done_ff <= 1'b0;
         last_rel_ff     <= '0;
         start_ff        <= '0;
         timing_ff       <= 1'b0;
         relay_a_ff      <= 1'b0;
         relay_b_ff      <= 1'b0;
         status_ff       <= dpq_pkg::STATUS_FAULT;
      end else if (advance) begin
         both_run_ff     <= both_run_in;
         release_done_ff <= release_done_in;
         last_rel_ff     <= last_rel_in;
         start_ff        <= start_in;
         timing_ff       <= timing_in;
         relay_a_ff      <= relay_a_in;
         relay_b_ff      <= relay_b_in;
         status_ff       <= status_in;
      end
   end

   // result register
   logic                       rsp_pulse_ff, rsp_blocked_ff, rsp_trip_ff;
   logic                       rsp_pa_ff, rsp_pb_ff;
   logic [dpq_pkg::STAT_W-1:0] rsp_status_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_pa_ff      <= relay_a_in;
         rsp_pb_ff      <= relay_b_in;
         rsp_pulse_ff   <= pulse;
         rsp_blocked_ff <= blocked;
         rsp_trip_ff    <= trip;
         rsp_status_ff  <= status_in;
      end
   end

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.pump_a_on       = rsp_pa_ff;
   assign rsp_ch.pump_b_on       = rsp_pb_ff;
   assign rsp_ch.cup_release     = rsp_pulse_ff;
   assign rsp_ch.release_blocked = rsp_blocked_ff;
   assign rsp_ch.watchdog_trip   = rsp_trip_ff;
   assign rsp_ch.status_code     = rsp_status_ff;

`ifndef SYNTHESIS
   a_release_xor_blocked: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_pulse_ff && rsp_blocked_ff))
      else $error("cup release and blocked flag in one transaction");

   a_trip_cuts_pumps: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_trip_ff) |->
         (!rsp_pa_ff && !rsp_pb_ff && rsp_status_ff == dpq_pkg::STATUS_FAULT))
      else $error("watchdog trip left a pump on or status not fault");

   a_one_pump: assert property (@(posedge clock) disable iff (reset)
      !(relay_a_ff && relay_b_ff))
      else $error("both relays on");

   a_trip_stops_timer: assert property (@(posedge clock) disable iff (reset)
      (advance && trip) |=> (!timing_ff && !relay_a_ff && !relay_b_ff))
      else $error("pump timer still running after watchdog trip");

   a_hold_when_stalled: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !advance) |-> !req_ch.ready)
      else $error("input register overwritten while stalled");
`endif

endmodule

// ----- tb/sv/tb_dual_pump_qualifier_with_watchdog_top.sv -----
// Testbench: random and directed samples with CSR phases, checked by a pump scoreboard.
module tb_dual_pump_qualifier_with_watchdog_top;

   typedef struct packed {
      logic                       pump_a_on;
      logic                       pump_b_on;
      logic                       cup_release;
      logic                       release_blocked;
      logic                       watchdog_trip;
      logic [dpq_pkg::STAT_W-1:0] status_code;
   } pump_result_type;

   typedef struct packed {
      logic [dpq_pkg::RUN_W-1:0]  on_thr;
      logic [dpq_pkg::RUN_W-1:0]  off_thr;
      logic [dpq_pkg::RUN_W-1:0]  drop_thr;
      logic [dpq_pkg::TIME_W-1:0] cooldown_ms;
      logic [dpq_pkg::TIME_W-1:0] max_run_ms;
   } pump_cfg_type;

   typedef struct packed {
      logic [dpq_pkg::RUN_W-1:0] low_run;
      logic [dpq_pkg::RUN_W-1:0] high_run;
      logic                      active;
   } line_state_type;

   class pump_scoreboard;
      pump_cfg_type               cfg;
      line_state_type             line_a, line_b;
      logic [dpq_pkg::RUN_W-1:0]  both_low_run;
      logic                       release_done, pump_timing, relay_a, relay_b;
      logic [dpq_pkg::TIME_W-1:0] last_release_ms, pump_start_ms;
      logic [dpq_pkg::STAT_W-1:0] status;
      pump_result_type            pending_results[$];
      int                         mismatches;
      int                         results_seen;

      function new();
         cfg = '{dpq_pkg::ON_THRESHOLD_RST, dpq_pkg::OFF_THRESHOLD_RST,
                 dpq_pkg::DROP_THRESHOLD_RST, dpq_pkg::DROP_COOLDOWN_MS_RST,
                 dpq_pkg::MAX_PUMP_MS_RST};
         line_a          = '0;
         line_b          = '0;
         both_low_run    = '0;
         release_done    = 1'b0;
         pump_timing     = 1'b0;
         relay_a         = 1'b0;
         relay_b         = 1'b0;
         last_release_ms = '0;
         pump_start_ms   = '0;
         status          = dpq_pkg::STATUS_FAULT;
         mismatches      = 0;
         results_seen    = 0;
      endfunction

      task report(string msg);
         $display("[%0t] ERROR: %s", $time, msg);
         mismatches++;
      endtask

      function logic [dpq_pkg::RUN_W-1:0] bump(logic [dpq_pkg::RUN_W-1:0] v);
         return (v == dpq_pkg::RUN_MAX) ? v : v + dpq_pkg::RUN_W'(1);
      endfunction

      // counters move first, then the threshold compare sees the new count
      function line_state_type qualify(logic low, line_state_type s);
         if (low) begin
            s.low_run  = bump(s.low_run);
            s.high_run = '0;
            if (!s.active && s.low_run >= cfg.on_thr) s.active = 1'b1;
         end else begin
            s.high_run = bump(s.high_run);
            s.low_run  = '0;
            if (s.active && s.high_run >= cfg.off_thr) s.active = 1'b0;
         end
         return s;
      endfunction

      function void start_pump_timer(logic [dpq_pkg::TIME_W-1:0] now_ms);
         if (!pump_timing) begin
            pump_timing   = 1'b1;
            pump_start_ms = now_ms;
         end
      endfunction

      function void note_sample(logic a_low, logic b_low, logic [dpq_pkg::TIME_W-1:0] now_ms);
         pump_result_type            want;
         logic [dpq_pkg::TIME_W-1:0] elapsed;
         want = '0;
         line_a = qualify(a_low, line_a);
         line_b = qualify(b_low, line_b);
         both_low_run = (a_low && b_low) ? bump(both_low_run) : '0;

         if (both_low_run >= cfg.drop_thr && line_a.active && line_b.active) begin
            if (!release_done) begin
               elapsed = now_ms - last_release_ms;
               if (elapsed >= cfg.cooldown_ms) begin
                  last_release_ms  = now_ms;
                  relay_a          = 1'b0;
                  relay_b          = 1'b0;
                  want.cup_release = 1'b1;
                  status           = dpq_pkg::STATUS_RELEASED;
               end else begin
                  want.release_blocked = 1'b1;
               end
               release_done = 1'b1;
            end
         end else if (line_a.active && !line_b.active) begin
            release_done = 1'b0;
            relay_a      = 1'b1;
            relay_b      = 1'b0;
            start_pump_timer(now_ms);
            status       = dpq_pkg::STATUS_PUMP_A;
         end else if (!line_a.active && line_b.active) begin
            release_done = 1'b0;
            relay_a      = 1'b0;
            relay_b      = 1'b1;
            start_pump_timer(now_ms);
            status       = dpq_pkg::STATUS_PUMP_B;
         end else if (!line_a.active && !line_b.active) begin
            release_done = 1'b0;
            relay_a      = 1'b0;
            relay_b      = 1'b0;
            pump_timing  = 1'b0;
            status       = dpq_pkg::STATUS_READY;
         end

         // watchdog drops the active flags but keeps the run counters
         elapsed = now_ms - pump_start_ms;
         if (pump_timing && elapsed > cfg.max_run_ms) begin
            relay_a            = 1'b0;
            relay_b            = 1'b0;
            pump_timing        = 1'b0;
            line_a.active      = 1'b0;
            line_b.active      = 1'b0;
            status             = dpq_pkg::STATUS_FAULT;
            want.watchdog_trip = 1'b1;
         end

         want.pump_a_on   = relay_a;
         want.pump_b_on   = relay_b;
         want.status_code = status;
         pending_results.push_back(want);
      endfunction

      task check_result(pump_result_type got);
         pump_result_type want;
         results_seen++;
         if (pending_results.size() == 0) begin
            report($sformatf("result %0d arrived with no transaction pending", results_seen));
         end else begin
            want = pending_results.pop_front();
            if (got !== want)
               report($sformatf({"result %0d: got a=%b b=%b rel=%b blk=%b trip=%b st=%0d,",
                                 " want a=%b b=%b rel=%b blk=%b trip=%b st=%0d"},
                                results_seen, got.pump_a_on, got.pump_b_on, got.cup_release,
                                got.release_blocked, got.watchdog_trip, got.status_code,
                                want.pump_a_on, want.pump_b_on, want.cup_release,
                                want.release_blocked, want.watchdog_trip, want.status_code));
         end
      endtask
   endclass

   logic                       clock = 1'b0;
   logic                       reset;
   logic                       csr_we;
   logic [dpq_pkg::IDX_W-1:0]  csr_index;
   logic [dpq_pkg::CSR_W-1:0]  csr_wdata;
   logic [dpq_pkg::TIME_W-1:0] sample_ms;
   bit                         tx_burst;
   bit                         rx_burst;
   pump_scoreboard             sb;

   dpq_req_if req_if ();
   dpq_rsp_if rsp_if ();

   dual_pump_qualifier_with_watchdog_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_if),
      .rsp_ch    (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #10 clock = ~clock;

   initial begin
      #10_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   task automatic send_sample(logic a_low, logic b_low, logic [dpq_pkg::TIME_W-1:0] stamp);
      int gap;
      if ($urandom_range(0, 15) == 0) tx_burst = !tx_burst;
      gap = tx_burst ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid      <= 1'b1;
      req_if.line_a_low <= a_low;
      req_if.line_b_low <= b_low;
      req_if.now_ms     <= stamp;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      sb.note_sample(a_low, b_low, stamp);
   endtask

   task automatic csr_put(logic [dpq_pkg::IDX_W-1:0] idx, logic [dpq_pkg::CSR_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   task automatic apply_config(pump_cfg_type c);
      int idx;
      csr_put(dpq_pkg::REG_ON_THRESHOLD, dpq_pkg::CSR_W'(c.on_thr));
      csr_put(dpq_pkg::REG_OFF_THRESHOLD, dpq_pkg::CSR_W'(c.off_thr));
      csr_put(dpq_pkg::REG_DROP_THRESHOLD, dpq_pkg::CSR_W'(c.drop_thr));
      csr_put(dpq_pkg::REG_DROP_COOLDOWN_MS, c.cooldown_ms);
      csr_put(dpq_pkg::REG_MAX_PUMP_MS, c.max_run_ms);
      // unmapped indexes must not disturb anything
      for (idx = int'(dpq_pkg::REG_MAX_PUMP_MS) + 1; idx < (1 << dpq_pkg::IDX_W); idx++)
         csr_put(dpq_pkg::IDX_W'(idx), $urandom);
      csr_we <= 1'b0;
      sb.cfg = c;
   endtask

   task automatic drain_results();
      int waited;
      waited = 0;
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending_results.size() != 0 && waited < 2000) begin
         @(posedge clock);
         waited++;
      end
      if (sb.pending_results.size() != 0) begin
         sb.report($sformatf("%0d expected results never arrived", sb.pending_results.size()));
         sb.pending_results.delete();
      end
      repeat (4) @(posedge clock);
   endtask

   function automatic logic [dpq_pkg::TIME_W-1:0] advance_ms(logic [dpq_pkg::TIME_W-1:0] t);
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 70) return t + $urandom_range(0, 5);
      if (pick < 92) return t + $urandom_range(0, 400);
      if (pick < 99) return t + $urandom_range(0, 5000);
      return $urandom;   // arbitrary jump, also backwards and across the wrap
   endfunction

   function automatic pump_cfg_type random_config();
      pump_cfg_type c;
      c.on_thr      = dpq_pkg::RUN_W'($urandom_range(1, 4));
      c.off_thr     = dpq_pkg::RUN_W'($urandom_range(1, 5));
      c.drop_thr    = dpq_pkg::RUN_W'($urandom_range(1, 8));
      c.cooldown_ms = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 3000);
      c.max_run_ms  = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 3000);
      return c;
   endfunction

   // bursts of held command patterns so the qualifiers get past their thresholds
   task automatic run_phase(int n_items, int long_odds);
      int   sent, len, kind, k;
      logic a_low, b_low;
      sent = 0;
      while (sent < n_items) begin
         kind = $urandom_range(0, 7);
         if (long_odds > 0 && $urandom_range(1, long_odds) == 1) kind = 8;
         case (kind)
            0, 1, 2, 3: len = $urandom_range(1, int'(sb.cfg.on_thr) + 8);
            4, 5:       len = $urandom_range(1, int'(sb.cfg.drop_thr) + 4);
            6:          len = $urandom_range(1, int'(sb.cfg.off_thr) + 4);
            7:          len = $urandom_range(1, 10);
            default:    len = $urandom_range(256, 262);   // drives counters into saturation
         endcase
         a_low = 1'($urandom_range(0, 1));
         b_low = 1'($urandom_range(0, 1));
         for (k = 0; k < len; k++) begin
            case (kind)
               0, 1: begin
                  a_low = 1'b1;
                  b_low = 1'b0;
               end
               2, 3: begin
                  a_low = 1'b0;
                  b_low = 1'b1;
               end
               4, 5: begin
                  a_low = 1'b1;
                  b_low = 1'b1;
               end
               6: begin
                  a_low = 1'b0;
                  b_low = 1'b0;
               end
               7: begin
                  a_low = 1'($urandom_range(0, 1));
                  b_low = 1'($urandom_range(0, 1));
               end
               default: ;
            endcase
            sample_ms = advance_ms(sample_ms);
            send_sample(a_low, b_low, sample_ms);
            sent++;
         end
      end
   endtask

   initial begin : result_sink
      int              stall;
      pump_result_type got;
      rsp_if.ready <= 1'b0;
      rx_burst = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if ($urandom_range(0, 15) == 0) rx_burst = !rx_burst;
         stall = rx_burst ? 0 : $urandom_range(0, 19);
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (rsp_if.valid !== 1'b1);
         got = {rsp_if.pump_a_on, rsp_if.pump_b_on, rsp_if.cup_release,
                rsp_if.release_blocked, rsp_if.watchdog_trip, rsp_if.status_code};
         sb.check_result(got);
      end
   end

   initial begin : stimulus
      pump_cfg_type next_cfg;
      int           phase;
      sb = new();
      reset             <= 1'b1;
      csr_we            <= 1'b0;
      csr_index         <= '0;
      csr_wdata         <= '0;
      req_if.valid      <= 1'b0;
      req_if.line_a_low <= 1'b0;
      req_if.line_b_low <= 1'b0;
      req_if.now_ms     <= '0;
      tx_burst  = 1'b0;
      sample_ms = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // register defaults: pump A runs, B joins and holds, watchdog cuts just past the limit
      send_sample(1'b0, 1'b0, 32'd100);
      send_sample(1'b1, 1'b0, 32'd101);
      send_sample(1'b1, 1'b0, 32'd102);
      send_sample(1'b1, 1'b0, 32'd103);
      send_sample(1'b1, 1'b1, 32'd104);
      send_sample(1'b1, 1'b1, 32'd105);
      send_sample(1'b1, 1'b1, 32'd106);
      send_sample(1'b0, 1'b1, 32'd20104);
      drain_results();

      // short thresholds: release, release refused by cooldown, trip and requalify, wrap
      apply_config('{8'd2, 8'd2, 8'd2, 32'd100, 32'd1000});
      send_sample(1'b0, 1'b0, 32'd29990);
      send_sample(1'b0, 1'b0, 32'd29991);
      send_sample(1'b1, 1'b1, 32'd30000);
      send_sample(1'b1, 1'b1, 32'd30001);
      send_sample(1'b1, 1'b1, 32'd30002);
      send_sample(1'b0, 1'b0, 32'd30010);
      send_sample(1'b0, 1'b0, 32'd30011);
      send_sample(1'b1, 1'b1, 32'd30050);
      send_sample(1'b1, 1'b1, 32'd30051);
      send_sample(1'b0, 1'b0, 32'd30060);
      send_sample(1'b0, 1'b0, 32'd30061);
      send_sample(1'b0, 1'b1, 32'd30070);
      send_sample(1'b0, 1'b1, 32'd30071);
      send_sample(1'b0, 1'b1, 32'd31072);
      send_sample(1'b0, 1'b1, 32'd31073);
      send_sample(1'b1, 1'b1, 32'hFFFF_FFFF);
      send_sample(1'b1, 1'b1, 32'h0000_0000);
      sample_ms = '0;
      drain_results();

      for (phase = 0; phase < 8; phase++) begin
         next_cfg = random_config();
         case (phase)
            1: next_cfg = '{8'd1, 8'd1, 8'd1, 32'd0, 32'd0};
            3: next_cfg = '{dpq_pkg::RUN_MAX, dpq_pkg::RUN_MAX, dpq_pkg::RUN_MAX,
                            32'hFFFF_FFFF, 32'hFFFF_FFFF};
            4: begin
               // zero thresholds are met by any run
               next_cfg.on_thr   = '0;
               next_cfg.off_thr  = '0;
               next_cfg.drop_thr = '0;
            end
            6: next_cfg = '{dpq_pkg::ON_THRESHOLD_RST, dpq_pkg::OFF_THRESHOLD_RST,
                            dpq_pkg::DROP_THRESHOLD_RST, dpq_pkg::DROP_COOLDOWN_MS_RST,
                            dpq_pkg::MAX_PUMP_MS_RST};
            default: ;
         endcase
         apply_config(next_cfg);
         if (phase == 3 || phase == 6) run_phase(40, 2);
         else run_phase(40, 0);
         drain_results();
      end

      repeat (10) @(posedge clock);
      if (sb.mismatches == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
